// ===== hw/rtl/ptc_pkg.sv =====
// Shared types and constants for the peer table with traffic counters.
package ptc_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int ACTION_W = 2;
    localparam int ADDR_W   = 32;
    localparam int ADD_W    = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int PEERS_W  = 7;
    localparam int CTR_W    = 64;

    // request action codes
    localparam logic [ACTION_W-1:0] ACT_ONLINE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_OFFLINE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TRAFFIC = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_BCAST   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ADDR_W-1:0]   peer_address;
        logic [ADD_W-1:0]    add_in;
        logic [ADD_W-1:0]    add_out;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [PEERS_W-1:0]  active_peers;
        logic [CTR_W-1:0]    entry_in_total;
        logic [CTR_W-1:0]    entry_out_total;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_ONLINE,
        OP_OFFLINE,
        OP_TRAFFIC,
        OP_BCAST
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t           op;
        logic [ADDR_W-1:0] peer_address;
        logic [ADD_W-1:0]  add_in;
        logic [ADD_W-1:0]  add_out;
    } cmd_t;

endpackage

// ===== hw/rtl/ptc_front.sv =====
// Front end: accepts requests, decodes the action and registers the command.
module ptc_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ptc_pkg::in_item_t in_data,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output ptc_pkg::cmd_t    cmd
);

    logic          cmd_valid_reg;
    logic          cmd_valid_next;
    ptc_pkg::cmd_t cmd_reg;
    ptc_pkg::cmd_t cmd_next;
    logic          accept;

    assign in_ready  = !cmd_valid_reg || cmd_ready;
    assign accept    = in_valid && in_ready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        cmd_next              = cmd_reg;
        cmd_next.peer_address = in_data.peer_address;
        cmd_next.add_in       = in_data.add_in;
        cmd_next.add_out      = in_data.add_out;
        case (in_data.action)
            ptc_pkg::ACT_ONLINE:  cmd_next.op = ptc_pkg::OP_ONLINE;
            ptc_pkg::ACT_OFFLINE: cmd_next.op = ptc_pkg::OP_OFFLINE;
            ptc_pkg::ACT_TRAFFIC: cmd_next.op = ptc_pkg::OP_TRAFFIC;
            ptc_pkg::ACT_BCAST:   cmd_next.op = ptc_pkg::OP_BCAST;
            default:              cmd_next.op = ptc_pkg::OP_BCAST;
        endcase
        if (accept)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            cmd_valid_next = 1'b0;
        end
        else
        begin
            cmd_valid_next = cmd_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ===== hw/rtl/ptc_cmd_fifo.sv =====
// Short command queue between the front end and the table engine.
module ptc_cmd_fifo
#(
    parameter int DEPTH = ptc_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  ptc_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ptc_pkg::cmd_t pop_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ptc_pkg::cmd_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("command queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

// ===== hw/rtl/ptc_engine.sv =====
// Table engine: slot scan, counter update and broadcast pass over the peer table.
module ptc_engine
#(
    parameter int TABLE_DEPTH = ptc_pkg::TABLE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  ptc_pkg::cmd_t      cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output ptc_pkg::out_item_t out_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = ptc_pkg::ADDR_W;
    localparam int CTR_W  = ptc_pkg::CTR_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_UPDATE,
        S_BCAST
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    ptc_pkg::cmd_t            cmd_reg;
    ptc_pkg::cmd_t            cmd_next;
    logic [IDX_W-1:0]         scan_idx_reg;
    logic [IDX_W-1:0]         scan_idx_next;
    logic                     scan_issue_reg;
    logic                     scan_issue_next;
    logic                     p_vld_reg;
    logic                     p_vld_next;
    logic [IDX_W-1:0]         p_idx_reg;
    logic [IDX_W-1:0]         p_idx_next;
    logic                     p_live_reg;
    logic                     p_live_next;
    logic                     hit_reg;
    logic                     hit_next;
    logic [IDX_W-1:0]         hit_idx_reg;
    logic [IDX_W-1:0]         hit_idx_next;
    logic                     free_found_reg;
    logic                     free_found_next;
    logic [IDX_W-1:0]         free_idx_reg;
    logic [IDX_W-1:0]         free_idx_next;
    logic [TABLE_DEPTH-1:0]   valid_reg;
    logic [TABLE_DEPTH-1:0]   valid_next;
    logic [CNT_W-1:0]         total_reg;
    logic [CNT_W-1:0]         total_next;
    logic                     res_valid_reg;
    logic                     res_valid_next;
    ptc_pkg::out_item_t       res_reg;
    ptc_pkg::out_item_t       res_next;

    // table memories, contents undefined until written
    logic [ADDR_W-1:0] addr_mem [TABLE_DEPTH];
    logic [CTR_W-1:0]  in_mem   [TABLE_DEPTH];
    logic [CTR_W-1:0]  out_mem  [TABLE_DEPTH];
    logic [ADDR_W-1:0] addr_rdata_reg;
    logic [CTR_W-1:0]  in_rdata_reg;
    logic [CTR_W-1:0]  out_rdata_reg;

    logic              addr_we;
    logic              in_we;
    logic              out_we;
    logic [IDX_W-1:0]  in_wa;
    logic [IDX_W-1:0]  out_wa;
    logic [IDX_W-1:0]  out_ra;
    logic [CTR_W-1:0]  in_wd;
    logic [CTR_W-1:0]  out_wd;

    logic                        match;
    logic                        res_load;
    logic [ptc_pkg::STATUS_W-1:0] r_status;
    logic [IDX_W-1:0]            r_idx;
    logic [CTR_W-1:0]            r_in;
    logic [CTR_W-1:0]            r_out;
    logic [IDX_W+ptc_pkg::SLOT_W-1:0]  slot_ext;
    logic [CNT_W+ptc_pkg::PEERS_W-1:0] peers_ext;

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;
    assign match     = p_vld_reg && p_live_reg && (addr_rdata_reg == cmd_reg.peer_address);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        scan_idx_next   = scan_idx_reg;
        scan_issue_next = scan_issue_reg;
        p_vld_next      = p_vld_reg;
        p_idx_next      = p_idx_reg;
        p_live_next     = p_live_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        total_next      = total_reg;
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        cmd_ready       = 1'b0;
        addr_we         = 1'b0;
        in_we           = 1'b0;
        out_we          = 1'b0;
        in_wa           = hit_idx_reg;
        out_wa          = hit_idx_reg;
        out_ra          = hit_idx_reg;
        in_wd           = '0;
        out_wd          = '0;
        res_load        = 1'b0;
        r_status        = ptc_pkg::ST_OK;
        r_idx           = '0;
        r_in            = '0;
        r_out           = '0;

        if (res_valid_reg && out_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = !res_valid_reg;
                if (cmd_valid && !res_valid_reg)
                begin
                    cmd_next        = cmd;
                    scan_idx_next   = '0;
                    scan_issue_next = 1'b1;
                    p_vld_next      = 1'b0;
                    hit_next        = 1'b0;
                    hit_idx_next    = '0;
                    free_found_next = 1'b0;
                    free_idx_next   = '0;
                    state_next      = (cmd.op == ptc_pkg::OP_BCAST) ? S_BCAST : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // one slot issued per cycle, compared in the next cycle
                p_vld_next  = scan_issue_reg;
                p_idx_next  = scan_idx_reg;
                p_live_next = valid_reg[scan_idx_reg];
                if (scan_issue_reg)
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        scan_issue_next = 1'b0;
                    end
                end
                if (p_vld_reg && !p_live_reg && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = p_idx_reg;
                end
                if (match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = p_idx_reg;
                    state_next   = S_FETCH;
                end
                else if (p_vld_reg && (p_idx_reg == LAST_IDX))
                begin
                    state_next = S_FETCH;
                end
            end

            S_FETCH:
            begin
                state_next = S_UPDATE;
            end

            S_UPDATE:
            begin
                res_load   = 1'b1;
                state_next = S_IDLE;
                case (cmd_reg.op)
                    ptc_pkg::OP_ONLINE:
                    begin
                        if (hit_reg)
                        begin
                            r_idx = hit_idx_reg;
                            r_in  = in_rdata_reg;
                            r_out = out_rdata_reg;
                        end
                        else if (free_found_reg)
                        begin
                            addr_we    = 1'b1;
                            in_we      = 1'b1;
                            out_we     = 1'b1;
                            in_wa      = free_idx_reg;
                            out_wa     = free_idx_reg;
                            valid_next[free_idx_reg] = 1'b1;
                            total_next = total_reg + CNT_W'(1);
                            r_idx      = free_idx_reg;
                        end
                        else
                        begin
                            r_status = ptc_pkg::ST_FULL;
                        end
                    end
                    ptc_pkg::OP_OFFLINE:
                    begin
                        if (hit_reg)
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                            total_next = total_reg - CNT_W'(1);
                            r_idx      = hit_idx_reg;
                            r_in       = in_rdata_reg;
                            r_out      = out_rdata_reg;
                        end
                        else
                        begin
                            r_status = ptc_pkg::ST_NOT_FOUND;
                        end
                    end
                    ptc_pkg::OP_TRAFFIC:
                    begin
                        if (hit_reg)
                        begin
                            in_we  = 1'b1;
                            out_we = 1'b1;
                            in_wd  = in_rdata_reg + CTR_W'(cmd_reg.add_in);
                            out_wd = out_rdata_reg + CTR_W'(cmd_reg.add_out);
                            r_idx  = hit_idx_reg;
                            r_in   = in_wd;
                            r_out  = out_wd;
                        end
                        else
                        begin
                            r_status = ptc_pkg::ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        r_status = ptc_pkg::ST_OK;
                    end
                endcase
            end

            S_BCAST:
            begin
                // read-modify-write of byte-out, one slot per cycle
                out_ra      = scan_idx_reg;
                p_vld_next  = scan_issue_reg;
                p_idx_next  = scan_idx_reg;
                p_live_next = valid_reg[scan_idx_reg];
                if (scan_issue_reg)
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        scan_issue_next = 1'b0;
                    end
                end
                if (p_vld_reg && p_live_reg)
                begin
                    out_we = 1'b1;
                    out_wa = p_idx_reg;
                    out_wd = out_rdata_reg + CTR_W'(cmd_reg.add_out);
                end
                if (p_vld_reg && (p_idx_reg == LAST_IDX))
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        slot_ext  = {{ptc_pkg::SLOT_W{1'b0}}, r_idx};
        peers_ext = {{ptc_pkg::PEERS_W{1'b0}}, total_next};
        if (res_load)
        begin
            res_valid_next           = 1'b1;
            res_next.status          = r_status;
            res_next.slot            = slot_ext[ptc_pkg::SLOT_W-1:0];
            res_next.active_peers    = peers_ext[ptc_pkg::PEERS_W-1:0];
            res_next.entry_in_total  = r_in;
            res_next.entry_out_total = r_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_issue_reg <= 1'b0;
            p_vld_reg      <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            total_reg      <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_issue_reg <= scan_issue_next;
            p_vld_reg      <= p_vld_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            total_reg      <= total_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        scan_idx_reg <= scan_idx_next;
        p_idx_reg    <= p_idx_next;
        p_live_reg   <= p_live_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        res_reg      <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (addr_we)
        begin
            addr_mem[free_idx_reg] <= cmd_reg.peer_address;
        end
        addr_rdata_reg <= addr_mem[scan_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (in_we)
        begin
            in_mem[in_wa] <= in_wd;
        end
        in_rdata_reg <= in_mem[hit_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (out_we)
        begin
            out_mem[out_wa] <= out_wd;
        end
        out_rdata_reg <= out_mem[out_ra];
    end

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(total_reg))
        else $error("peer count disagrees with valid flags");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !res_valid_reg)
        else $error("engine busy while a result is pending");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.status == ptc_pkg::ST_FULL)) |-> (total_reg == FULL_CNT))
        else $error("full reported on a table with free slots");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.status != ptc_pkg::ST_OK)) |->
        ((res_reg.slot == '0) && (res_reg.entry_in_total == '0) &&
         (res_reg.entry_out_total == '0)))
        else $error("failed request reports slot or counters");

endmodule

// ===== hw/rtl/peer_table_with_traffic_counters.sv =====
// Top level of the peer table with per-peer traffic counters.
// A request takes one pass over the table in the engine, one slot per cycle through the
// single read port of the address memory. Online, offline and traffic stop at the
// matching slot, or scan every slot on a miss, and then pass through a fetch and an
// update state. Broadcast is a read-modify-write sweep of the byte-out memory, one slot
// per cycle. The front end adds one register stage and the command queue holds
// QUEUE_DEPTH decoded requests, so new requests are taken while the engine works and
// while a finished result waits in the output register. The engine starts the next
// request once its result has been taken. Valid flags and the peer count are cleared
// by reset; addresses and counters live in memories that are written before they are
// read, so no clearing pass runs after reset.
module peer_table_with_traffic_counters
#(
    parameter int TABLE_DEPTH = ptc_pkg::TABLE_DEPTH_DEF,   // 2 .. 64 slots
    parameter int QUEUE_DEPTH = ptc_pkg::QUEUE_DEPTH_DEF    // at least 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ptc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ptc_pkg::out_item_t out_data
);

    // decoded request from the front end into the queue
    logic          front_valid;
    logic          front_ready;
    ptc_pkg::cmd_t front_cmd;

    // queue head into the engine
    logic          eng_valid;
    logic          eng_ready;
    ptc_pkg::cmd_t eng_cmd;

    ptc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    ptc_cmd_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (eng_valid),
        .pop_ready  (eng_ready),
        .pop_cmd    (eng_cmd)
    );

    // lookup, claim, free and counter updates; owns the table memories
    ptc_engine
    #(
        .TABLE_DEPTH (TABLE_DEPTH)
    )
    u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (eng_valid),
        .cmd_ready (eng_ready),
        .cmd       (eng_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
